### hdl/kwb_pkg.sv
// Package for the keystroke word buffer retyper: key codes, register map,
// configuration, command and result types shared by all modules.
// No dependencies.
package kwb_pkg;

	localparam int WORD_DEPTH_DEF = 8;
	localparam int CMD_DEPTH      = 2;
	localparam int CMD_PTR_W      = $clog2(CMD_DEPTH);
	localparam int CMD_CNT_W      = $clog2(CMD_DEPTH + 1);

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;
	localparam int TIMEOUT_W = 22;

	localparam logic [1:0] REG_TOGGLE_FIRST  = 2'd0;
	localparam logic [1:0] REG_TOGGLE_SECOND = 2'd1;
	localparam logic [1:0] REG_IDLE_TIMEOUT  = 2'd2;

	localparam logic [7:0] TOGGLE_FIRST_RST  = 8'd164;
	localparam logic [7:0] TOGGLE_SECOND_RST = 8'd160;

	localparam logic [7:0] KEY_NONE   = 8'd0;
	localparam logic [7:0] KEY_BACK   = 8'd8;
	localparam logic [7:0] KEY_SHIFT  = 8'd16;
	localparam logic [7:0] KEY_CTRL   = 8'd17;
	localparam logic [7:0] KEY_ALT    = 8'd18;
	localparam logic [7:0] KEY_PAUSE  = 8'd19;
	localparam logic [7:0] KEY_LEFT   = 8'd37;
	localparam logic [7:0] KEY_LSHIFT = 8'd160;
	localparam logic [7:0] KEY_RSHIFT = 8'd161;
	localparam logic [7:0] KEY_LCTRL  = 8'd162;
	localparam logic [7:0] KEY_RCTRL  = 8'd163;
	localparam logic [7:0] KEY_LALT   = 8'd164;
	localparam logic [7:0] KEY_RALT   = 8'd165;
	localparam logic [7:0] KEY_DIGIT0 = 8'd48;
	localparam logic [7:0] KEY_LETZ   = 8'd90;
	localparam logic [7:0] KEY_NUM0   = 8'd96;
	localparam logic [7:0] KEY_DIVIDE = 8'd111;
	localparam logic [7:0] KEY_OEM1   = 8'd186;
	localparam logic [7:0] KEY_OEM7   = 8'd222;

	localparam logic RES_VERDICT = 1'b0;
	localparam logic RES_KEY     = 1'b1;

	typedef struct packed {
		logic [7:0]           toggle_first;
		logic [7:0]           toggle_second;
		logic [TIMEOUT_W-1:0] idle_timeout;
	} cfg_t;

	typedef struct packed {
		logic replay;
		logic pass_on;
	} cmd_t;

	typedef struct packed {
		logic       shift;
		logic [7:0] scan;
		logic [7:0] key;
	} word_entry_t;

	typedef struct packed {
		logic       last;
		logic       pass_on;
		logic       release_k;
		logic [7:0] scan;
		logic [7:0] key;
		logic       kind;
	} res_t;

	function automatic res_t make_key(logic [7:0] key, logic [7:0] scan, logic rel);
		res_t r;
		r.kind      = RES_KEY;
		r.key       = key;
		r.scan      = scan;
		r.release_k = rel;
		r.pass_on   = 1'b0;
		r.last      = 1'b0;
		return r;
	endfunction

	function automatic res_t make_verdict(logic pass);
		res_t r;
		r.kind      = RES_VERDICT;
		r.key       = KEY_NONE;
		r.scan      = 8'd0;
		r.release_k = 1'b0;
		r.pass_on   = pass;
		r.last      = 1'b1;
		return r;
	endfunction

endpackage

### hdl/kwb_front.sv
// Front end: accepts key events, tracks modifiers and the idle timer,
// keeps the word buffer (circular memory) and queues one command per event.
// Depends on kwb_pkg.
module kwb_front #(
	parameter int WORD_DEPTH = kwb_pkg::WORD_DEPTH_DEF,
	localparam int IDX_W = $clog2(WORD_DEPTH),
	localparam int LEN_W = $clog2(WORD_DEPTH + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          in_key,
	input  logic [7:0]          in_scan,
	input  logic                in_down,
	input  logic [31:0]         in_time,
	input  kwb_pkg::cfg_t       cfg,
	output logic                push,
	output kwb_pkg::cmd_t       push_cmd,
	input  logic                push_ready,
	input  logic                replay_done,
	input  logic [IDX_W-1:0]    rd_idx,
	output kwb_pkg::word_entry_t rd_data,
	output logic [LEN_W-1:0]    word_len
);

	localparam int HALF = WORD_DEPTH / 2;

	kwb_pkg::word_entry_t mem [WORD_DEPTH];
	kwb_pkg::word_entry_t rd_data_q;

	logic [LEN_W-1:0] len_q;
	logic [IDX_W-1:0] base_q;
	logic             shift_q, ctrl_q, alt_q, busy_q;
	logic [31:0]      prev_time_q;

	logic             accept, shift_n, ctrl_n, alt_n, plain, tmo_on, tmo_hit;
	logic             any_mod, word_key, wr_en;
	logic [LEN_W-1:0] len_e, len_n, len_inc;
	logic [IDX_W-1:0] base_n, waddr;
	logic [31:0]      gap;

	function automatic logic [IDX_W-1:0] phys(logic [IDX_W-1:0] b, logic [IDX_W-1:0] off);
		logic [IDX_W:0] s;
		s = {1'b0, b} + {1'b0, off};
		if (s >= (IDX_W+1)'(WORD_DEPTH))
			s = s - (IDX_W+1)'(WORD_DEPTH);
		return s[IDX_W-1:0];
	endfunction

	assign in_ready = !busy_q && push_ready;
	assign accept   = in_valid && in_ready;
	assign push     = accept;
	assign word_len = len_q;
	assign rd_data  = rd_data_q;

	always_comb begin
		shift_n = shift_q;
		ctrl_n  = ctrl_q;
		alt_n   = alt_q;
		if (in_key == kwb_pkg::KEY_SHIFT || in_key == kwb_pkg::KEY_LSHIFT ||
				in_key == kwb_pkg::KEY_RSHIFT)
			shift_n = in_down;
		if (in_key == kwb_pkg::KEY_CTRL || in_key == kwb_pkg::KEY_LCTRL ||
				in_key == kwb_pkg::KEY_RCTRL)
			ctrl_n = in_down;
		if (in_key == kwb_pkg::KEY_ALT || in_key == kwb_pkg::KEY_LALT ||
				in_key == kwb_pkg::KEY_RALT)
			alt_n = in_down;

		plain    = (in_key == kwb_pkg::KEY_NONE) || !in_down;
		tmo_on   = cfg.idle_timeout != '0;
		gap      = in_time - prev_time_q;
		tmo_hit  = tmo_on && (gap >= {{(32-kwb_pkg::TIMEOUT_W){1'b0}}, cfg.idle_timeout});
		len_e    = tmo_hit ? '0 : len_q;
		len_inc  = len_e + LEN_W'(1);
		any_mod  = shift_n || ctrl_n || alt_n;
		word_key = (in_key >= kwb_pkg::KEY_DIGIT0 && in_key <= kwb_pkg::KEY_LETZ) ||
			(in_key >= kwb_pkg::KEY_NUM0 && in_key <= kwb_pkg::KEY_DIVIDE) ||
			(in_key >= kwb_pkg::KEY_OEM1 && in_key <= kwb_pkg::KEY_OEM7);

		len_n            = len_e;
		base_n           = base_q;
		wr_en            = 1'b0;
		waddr            = phys(base_q, len_e[IDX_W-1:0]);
		push_cmd.replay  = 1'b0;
		push_cmd.pass_on = 1'b1;

		if (plain) begin
			len_n = len_q;
		end else if (!any_mod && in_key == kwb_pkg::KEY_PAUSE) begin
			if (len_e != '0) begin
				push_cmd.replay  = 1'b1;
				push_cmd.pass_on = 1'b0;
			end
		end else if (shift_n && !ctrl_n && !alt_n && in_key == kwb_pkg::KEY_PAUSE) begin
			push_cmd.pass_on = 1'b0;
		end else if (in_key == kwb_pkg::KEY_BACK || in_key == kwb_pkg::KEY_LEFT) begin
			if (len_e != '0)
				len_n = len_e - LEN_W'(1);
		end else if (word_key && !ctrl_n && !alt_n) begin
			wr_en = 1'b1;
			len_n = len_inc;
			if (len_inc == LEN_W'(WORD_DEPTH)) begin
				base_n = phys(base_q, IDX_W'(WORD_DEPTH - HALF));
				len_n  = LEN_W'(HALF);
			end
		end else if (in_key[7:1] != kwb_pkg::KEY_LSHIFT[7:1]) begin
			len_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			base_q      <= '0;
			shift_q     <= 1'b0;
			ctrl_q      <= 1'b0;
			alt_q       <= 1'b0;
			busy_q      <= 1'b0;
			prev_time_q <= '0;
		end else begin
			if (replay_done)
				busy_q <= 1'b0;
			if (accept) begin
				shift_q <= shift_n;
				ctrl_q  <= ctrl_n;
				alt_q   <= alt_n;
				len_q   <= len_n;
				base_q  <= base_n;
				if (!plain && tmo_on)
					prev_time_q <= in_time;
				if (push_cmd.replay)
					busy_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && wr_en)
			mem[waddr] <= '{shift: shift_n, scan: in_scan, key: in_key};
		rd_data_q <= mem[phys(base_q, rd_idx)];
	end

endmodule

### hdl/kwb_cmd_fifo.sv
// Short command queue between the front end and the replay sequencer.
// Depends on kwb_pkg.
module kwb_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  kwb_pkg::cmd_t push_cmd,
	output logic          not_full,
	input  logic          pop,
	output logic          not_empty,
	output kwb_pkg::cmd_t head
);

	kwb_pkg::cmd_t                  slots [kwb_pkg::CMD_DEPTH];
	logic [kwb_pkg::CMD_PTR_W-1:0] wr_q, rd_q;
	logic [kwb_pkg::CMD_CNT_W-1:0] cnt_q;

	function automatic logic [kwb_pkg::CMD_PTR_W-1:0] nxt(
			logic [kwb_pkg::CMD_PTR_W-1:0] p);
		if (p == kwb_pkg::CMD_PTR_W'(kwb_pkg::CMD_DEPTH - 1))
			return '0;
		return p + kwb_pkg::CMD_PTR_W'(1);
	endfunction

	assign not_full  = cnt_q != kwb_pkg::CMD_CNT_W'(kwb_pkg::CMD_DEPTH);
	assign not_empty = cnt_q != '0;
	assign head      = slots[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= nxt(wr_q);
			if (pop)
				rd_q <= nxt(rd_q);
			if (push && !pop)
				cnt_q <= cnt_q + kwb_pkg::CMD_CNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - kwb_pkg::CMD_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slots[wr_q] <= push_cmd;
	end

endmodule

### hdl/kwb_back.sv
// Back end: takes queued commands, emits verdicts and walks the word buffer
// to replay it, at most one result word a cycle into the output register.
// Depends on kwb_pkg.
module kwb_back #(
	parameter int WORD_DEPTH = kwb_pkg::WORD_DEPTH_DEF,
	localparam int IDX_W = $clog2(WORD_DEPTH),
	localparam int LEN_W = $clog2(WORD_DEPTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	input  kwb_pkg::cmd_t        cmd,
	output logic                 cmd_pop,
	input  kwb_pkg::cfg_t        cfg,
	input  logic [LEN_W-1:0]     word_len,
	output logic [IDX_W-1:0]     rd_idx,
	input  kwb_pkg::word_entry_t rd_data,
	output logic                 replay_done,
	output logic                 out_valid,
	input  logic                 out_ready,
	output kwb_pkg::res_t        out_res
);

	typedef enum logic [3:0] {
		S_IDLE, S_BS_DN, S_BS_UP, S_T1_DN, S_T2_DN, S_T2_UP, S_T1_UP,
		S_RD, S_SH_DN, S_K_DN, S_K_UP, S_SH_UP, S_VERDICT
	} state_t;

	state_t           state_q;
	logic [LEN_W-1:0] cnt_q;
	logic             out_valid_q, done_q;
	kwb_pkg::res_t    out_q;
	logic             out_free, cnt_end, load;
	logic [LEN_W-1:0] cnt_inc;

	assign out_free    = !out_valid_q || out_ready;
	assign cmd_pop     = (state_q == S_IDLE) && cmd_valid && out_free;
	assign cnt_inc     = cnt_q + LEN_W'(1);
	assign cnt_end     = cnt_inc == word_len;
	assign rd_idx      = cnt_q[IDX_W-1:0];
	assign replay_done = done_q;
	assign out_valid   = out_valid_q;
	assign out_res     = out_q;

	always_comb begin
		unique case (state_q) inside
			S_IDLE:  load = cmd_pop && !cmd.replay;
			S_SH_DN: load = out_free && rd_data.shift;
			S_BS_DN, S_BS_UP, S_T1_DN, S_T2_DN, S_T2_UP, S_T1_UP, S_K_DN, S_K_UP,
			S_SH_UP, S_VERDICT:
				load = out_free;
			default: load = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			done_q      <= 1'b0;
			out_q       <= '0;
		end else begin
			done_q <= (state_q == S_VERDICT) && out_free;
			if (load)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cmd_pop) begin
						if (cmd.replay) begin
							cnt_q   <= '0;
							state_q <= S_BS_DN;
						end else begin
							out_q <= kwb_pkg::make_verdict(cmd.pass_on);
						end
					end
				end
				S_BS_DN: begin
					if (out_free) begin
						out_q   <= kwb_pkg::make_key(kwb_pkg::KEY_BACK, 8'd0, 1'b0);
						state_q <= S_BS_UP;
					end
				end
				S_BS_UP: begin
					if (out_free) begin
						out_q   <= kwb_pkg::make_key(kwb_pkg::KEY_BACK, 8'd0, 1'b1);
						cnt_q   <= cnt_inc;
						state_q <= cnt_end ? S_T1_DN : S_BS_DN;
					end
				end
				S_T1_DN: begin
					if (out_free) begin
						out_q   <= kwb_pkg::make_key(cfg.toggle_first, 8'd0, 1'b0);
						state_q <= (cfg.toggle_second != 8'd0) ? S_T2_DN : S_T1_UP;
					end
				end
				S_T2_DN: begin
					if (out_free) begin
						out_q   <= kwb_pkg::make_key(cfg.toggle_second, 8'd0, 1'b0);
						state_q <= S_T2_UP;
					end
				end
				S_T2_UP: begin
					if (out_free) begin
						out_q   <= kwb_pkg::make_key(cfg.toggle_second, 8'd0, 1'b1);
						state_q <= S_T1_UP;
					end
				end
				S_T1_UP: begin
					if (out_free) begin
						out_q   <= kwb_pkg::make_key(cfg.toggle_first, 8'd0, 1'b1);
						cnt_q   <= '0;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_SH_DN;
				end
				S_SH_DN: begin
					if (!rd_data.shift) begin
						state_q <= S_K_DN;
					end else if (out_free) begin
						out_q   <= kwb_pkg::make_key(kwb_pkg::KEY_SHIFT, 8'd0, 1'b0);
						state_q <= S_K_DN;
					end
				end
				S_K_DN: begin
					if (out_free) begin
						out_q   <= kwb_pkg::make_key(rd_data.key, rd_data.scan, 1'b0);
						state_q <= S_K_UP;
					end
				end
				S_K_UP: begin
					if (out_free) begin
						out_q <= kwb_pkg::make_key(rd_data.key, rd_data.scan, 1'b1);
						if (rd_data.shift) begin
							state_q <= S_SH_UP;
						end else begin
							cnt_q   <= cnt_inc;
							state_q <= cnt_end ? S_VERDICT : S_RD;
						end
					end
				end
				S_SH_UP: begin
					if (out_free) begin
						out_q   <= kwb_pkg::make_key(kwb_pkg::KEY_SHIFT, 8'd0, 1'b1);
						cnt_q   <= cnt_inc;
						state_q <= cnt_end ? S_VERDICT : S_RD;
					end
				end
				S_VERDICT: begin
					if (out_free) begin
						out_q   <= kwb_pkg::make_verdict(1'b0);
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### hdl/keystroke_word_buffer_retyper_unit.sv
// Keystroke word buffer retyper: top level with register port and stream packing.
// A verdict-only event is written into the command queue, then the sequencer pops it into
// the output register. Throughput: one such event a cycle while the queue has room and the
// output is taken; a replay stalls the input until the sequencer has retyped the word and sent its verdict.
// Reset clears modifiers, word length, idle timer and queue; the word store is not cleared.
// Depends on kwb_pkg, kwb_front, kwb_cmd_fifo and kwb_back.
module keystroke_word_buffer_retyper_unit #(
	parameter int WORD_DEPTH = kwb_pkg::WORD_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [kwb_pkg::PADDR_W-1:0] paddr,
	input  logic [kwb_pkg::PDATA_W-1:0] pwdata,
	output logic [kwb_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [47:0]                 s_axis_tdata,  // key_code, scan_code, time_ms
	input  logic                        s_axis_tuser,  // key_down
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [23:0]                 m_axis_tdata,  // out_key, out_scan, out_release, pass_on
	output logic                        m_axis_tuser,  // result_kind
	output logic                        m_axis_tlast   // last
);

	localparam int IDX_W = $clog2(WORD_DEPTH);
	localparam int LEN_W = $clog2(WORD_DEPTH + 1);

	kwb_pkg::cfg_t        cfg_q;
	kwb_pkg::cmd_t        push_cmd, head;
	kwb_pkg::word_entry_t rd_data;
	kwb_pkg::res_t        res;
	logic                 push, not_full, pop, not_empty, replay_done, wr;
	logic [IDX_W-1:0]     rd_idx;
	logic [LEN_W-1:0]     word_len;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.toggle_first  <= kwb_pkg::TOGGLE_FIRST_RST;
			cfg_q.toggle_second <= kwb_pkg::TOGGLE_SECOND_RST;
			cfg_q.idle_timeout  <= '0;
		end else if (wr) begin
			case (paddr[3:2])
				kwb_pkg::REG_TOGGLE_FIRST:  cfg_q.toggle_first  <= pwdata[7:0];
				kwb_pkg::REG_TOGGLE_SECOND: cfg_q.toggle_second <= pwdata[7:0];
				kwb_pkg::REG_IDLE_TIMEOUT:
					cfg_q.idle_timeout <= pwdata[kwb_pkg::TIMEOUT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			kwb_pkg::REG_TOGGLE_FIRST:  prdata = {24'd0, cfg_q.toggle_first};
			kwb_pkg::REG_TOGGLE_SECOND: prdata = {24'd0, cfg_q.toggle_second};
			kwb_pkg::REG_IDLE_TIMEOUT:
				prdata = {{(kwb_pkg::PDATA_W-kwb_pkg::TIMEOUT_W){1'b0}}, cfg_q.idle_timeout};
			default: prdata = '0;
		endcase
	end

	kwb_front #(.WORD_DEPTH(WORD_DEPTH)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_key     (s_axis_tdata[7:0]),
		.in_scan    (s_axis_tdata[15:8]),
		.in_down    (s_axis_tuser),
		.in_time    (s_axis_tdata[47:16]),
		.cfg        (cfg_q),
		.push       (push),
		.push_cmd   (push_cmd),
		.push_ready (not_full),
		.replay_done(replay_done),
		.rd_idx     (rd_idx),
		.rd_data    (rd_data),
		.word_len   (word_len)
	);

	kwb_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.not_full (not_full),
		.pop      (pop),
		.not_empty(not_empty),
		.head     (head)
	);

	kwb_back #(.WORD_DEPTH(WORD_DEPTH)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (not_empty),
		.cmd        (head),
		.cmd_pop    (pop),
		.cfg        (cfg_q),
		.word_len   (word_len),
		.rd_idx     (rd_idx),
		.rd_data    (rd_data),
		.replay_done(replay_done),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_res    (res)
	);

	assign m_axis_tdata = {6'd0, res.pass_on, res.release_k, res.scan, res.key};
	assign m_axis_tuser = res.kind;
	assign m_axis_tlast = res.last;

endmodule
